### hdl/rerr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rerr_pkg
// Shared types and constants for the relative error metric block.
// ----------------------------------------------------------------------------
package rerr_pkg;

  localparam int SMP_W  = 32;             // sample port width
  localparam int TOL_W  = 31;             // tolerance register width
  localparam int ERR_W  = 48;             // error, Q32.16
  localparam int SUM_W  = 64;             // running sum, Q48.16
  localparam int CNT_W  = 32;             // request count
  localparam int DIFF_W = SMP_W + 1;      // magnitude of a sample difference
  localparam int MAG_W  = SMP_W;          // magnitude of one sample
  localparam int EXT_W  = SMP_W + 2;      // signed working width
  localparam int DVD_W  = DIFF_W + ERR_W; // dividend window
  localparam int STEP_W = $clog2(ERR_W);

  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(65536);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PREP  = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_WRITE = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;      // capture an input request
    logic prep;      // form magnitudes and pick the path
    logic step;      // one quotient bit
    logic out_load;  // update totals and fill the output register
  } cmd_t;

  typedef struct packed {
    logic skip;      // no division needed
  } stat_t;

endpackage

### hdl/rerr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rerr_ctrl
// Sequencer: accepts a request, runs the divider for the quotient bits and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module rerr_ctrl
  import rerr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        step_nxt  = '0;
        state_nxt = stat.skip ? ST_WRITE : ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(ERR_W - 1)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/rerr_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rerr_dpath
// Datapath: sample magnitudes, restoring divider, running totals, tolerance
// register and output register.
// ----------------------------------------------------------------------------
module rerr_dpath
  import rerr_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic              cfg_we,
  input  logic [TOL_W-1:0]  cfg_tolerance,
  input  logic [SMP_W-1:0]  in_original_sample,
  input  logic [SMP_W-1:0]  in_approx_sample,
  input  logic              in_last_item,
  output logic [ERR_W-1:0]  out_rel_error,
  output logic [ERR_W-1:0]  out_max_error,
  output logic [SUM_W-1:0]  out_sum_error,
  output logic [CNT_W-1:0]  out_item_count,
  output logic              out_set_done
);

  logic [TOL_W-1:0]          tol_r;
  logic signed [EXT_W-1:0]   diff_r;
  logic [MAG_W-1:0]          omag_r;
  logic                      last_r;
  logic [MAG_W-1:0]          rem_r;
  logic [ERR_W-1:0]          low_r;
  logic [ERR_W-1:0]          max_r;
  logic [SUM_W-1:0]          sum_r;
  logic [CNT_W-1:0]          cnt_r;

  logic signed [SAMPLE_WIDTH-1:0] o_n, a_n;
  logic signed [EXT_W-1:0]   o_x, a_x, o_neg;
  logic signed [EXT_W-1:0]   d_neg;
  logic [DIFF_W-1:0]         dmag;
  logic [DVD_W-1:0]          dvd;
  logic                      is_abs, ovf;
  logic [DIFF_W-1:0]         trial;
  logic [DIFF_W:0]           trial_sub;
  logic                      ge;
  logic [ERR_W-1:0]          max_nxt;
  logic [SUM_W:0]            sum_add;
  logic [SUM_W-1:0]          sum_nxt;
  logic [CNT_W-1:0]          cnt_nxt;

  // request capture
  assign o_n   = in_original_sample[SAMPLE_WIDTH-1:0];
  assign a_n   = in_approx_sample[SAMPLE_WIDTH-1:0];
  assign o_x   = EXT_W'(o_n);
  assign a_x   = EXT_W'(a_n);
  assign o_neg = -o_x;

  // path selection
  assign d_neg  = -diff_r;
  assign dmag   = diff_r[EXT_W-1] ? d_neg[DIFF_W-1:0] : diff_r[DIFF_W-1:0];
  assign dvd    = DVD_W'(dmag) << FRAC_BITS;
  assign is_abs = {1'b0, omag_r} < {2'b00, tol_r};
  assign ovf    = dvd[DVD_W-1:ERR_W] >= {1'b0, omag_r};
  assign stat.skip = is_abs || ovf;

  // one quotient bit
  assign trial     = {rem_r, low_r[ERR_W-1]};
  assign trial_sub = {1'b0, trial} - {2'b00, omag_r};
  assign ge        = !trial_sub[DIFF_W];

  // totals
  assign max_nxt = (low_r > max_r) ? low_r : max_r;
  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(low_r);
  assign sum_nxt = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
  assign cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
      max_r <= '0;
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_tolerance;
      end
      if (cmd.out_load) begin
        max_r <= last_r ? '0 : max_nxt;
        sum_r <= last_r ? '0 : sum_nxt;
        cnt_r <= last_r ? '0 : cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diff_r <= o_x - a_x;
      omag_r <= o_x[EXT_W-1] ? o_neg[MAG_W-1:0] : o_x[MAG_W-1:0];
      last_r <= in_last_item;
    end
    if (cmd.prep) begin
      rem_r <= dvd[DVD_W-2:ERR_W];
      if (is_abs) begin
        low_r <= ERR_W'(dmag);
      end else if (ovf) begin
        low_r <= ERR_MAX;
      end else begin
        low_r <= dvd[ERR_W-1:0];
      end
    end
    if (cmd.step) begin
      rem_r <= ge ? trial_sub[MAG_W-1:0] : trial[MAG_W-1:0];
      low_r <= {low_r[ERR_W-2:0], ge};
    end
    if (cmd.out_load) begin
      out_rel_error  <= low_r;
      out_max_error  <= max_nxt;
      out_sum_error  <= sum_nxt;
      out_item_count <= cnt_nxt;
      out_set_done   <= last_r;
    end
  end

endmodule

### hdl/relative_error_metric.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_error_metric
// Per-pair relative error with running maximum, sum and count per data set.
//
//   channel  handshake            payload
//   in       in_valid / in_stall   in_original_sample, in_approx_sample,
//                                  in_last_item
//   out      out_valid / out_stall out_rel_error, out_max_error,
//                                  out_sum_error, out_item_count, out_set_done
//   cfg      cfg_valid / cfg_ready cfg_tolerance
//
// A divided request goes through capture, path select, 48 quotient bits of the
// one-bit-per-cycle restoring divider and write-out; the absolute or saturated
// path skips the divider.
// The output register holds one result, so a new request is taken while the
// previous result waits; a stalled result holds back only the write-out.
// Synchronous active-low reset clears totals and sets tolerance to 1.0.
// ----------------------------------------------------------------------------
module relative_error_metric
  import rerr_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SMP_W-1:0]  in_original_sample,
  input  logic [SMP_W-1:0]  in_approx_sample,
  input  logic              in_last_item,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ERR_W-1:0]  out_rel_error,
  output logic [ERR_W-1:0]  out_max_error,
  output logic [SUM_W-1:0]  out_sum_error,
  output logic [CNT_W-1:0]  out_item_count,
  output logic              out_set_done,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TOL_W-1:0]  cfg_tolerance
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = rst_n;

  rerr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rerr_dpath #(
    .FRAC_BITS    (FRAC_BITS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_tolerance      (cfg_tolerance),
    .in_original_sample (in_original_sample),
    .in_approx_sample   (in_approx_sample),
    .in_last_item       (in_last_item),
    .out_rel_error      (out_rel_error),
    .out_max_error      (out_max_error),
    .out_sum_error      (out_sum_error),
    .out_item_count     (out_item_count),
    .out_set_done       (out_set_done)
  );

endmodule

### sim/tb_relative_error_metric.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_relative_error_metric
// Self-checking testbench for the relative error metric block.
//
// Sample pairs are offered on the input channel under several tolerance
// settings and idling patterns. Each accepted request is run through an
// internal predictor of the per-pair error and the per-set running maximum,
// sum and count. Every result taken from the output channel is compared field
// by field with the oldest prediction. Directed requests cover the sample
// extremes, both error paths, the zero-divisor case and set closure. A long
// output hold fills the block.
// ----------------------------------------------------------------------------
module tb_relative_error_metric;
  import rerr_pkg::*;

  localparam int FRAC_BITS  = 16;
  localparam int LONG_HOLD  = 1500;
  localparam int DRAIN_WAIT = 60;
  localparam logic [TOL_W-1:0] TOL_MAX = {TOL_W{1'b1}};

  typedef struct packed {
    logic [ERR_W-1:0] rel;
    logic [ERR_W-1:0] peak;
    logic [SUM_W-1:0] total;
    logic [CNT_W-1:0] count;
    logic             done;
  } metric_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [SMP_W-1:0] in_original_sample = '0;
  logic [SMP_W-1:0] in_approx_sample = '0;
  logic             in_last_item = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ERR_W-1:0] out_rel_error;
  logic [ERR_W-1:0] out_max_error;
  logic [SUM_W-1:0] out_sum_error;
  logic [CNT_W-1:0] out_item_count;
  logic             out_set_done;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [TOL_W-1:0] cfg_tolerance = '0;

  // predictor state
  logic [TOL_W-1:0] tolerance_now = TOL_RESET;
  logic [ERR_W-1:0] set_peak = '0;
  logic [SUM_W-1:0] set_total = '0;
  logic [CNT_W-1:0] set_count = '0;

  metric_result_t expected_results[$];
  int mismatch_count = 0;
  int src_idle_pct = 0;
  int rcv_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;

  relative_error_metric #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_WIDTH(SMP_W)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_original_sample(in_original_sample),
    .in_approx_sample  (in_approx_sample),
    .in_last_item      (in_last_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rel_error     (out_rel_error),
    .out_max_error     (out_max_error),
    .out_sum_error     (out_sum_error),
    .out_item_count    (out_item_count),
    .out_set_done      (out_set_done),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_tolerance     (cfg_tolerance)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [ERR_W-1:0] pair_error(input logic [SMP_W-1:0] orig,
                                                  input logic [SMP_W-1:0] approx);
    longint o;
    longint a;
    longint d;
    logic [63:0] diff;
    logic [63:0] mag;
    logic [63:0] quot;
    o = longint'($signed(orig));
    a = longint'($signed(approx));
    d = o - a;
    diff = (d < 0) ? -d : d;
    mag = (o < 0) ? -o : o;
    if (mag < tolerance_now) return diff[ERR_W-1:0];
    if (mag == 0) return ERR_MAX;
    quot = (diff << FRAC_BITS) / mag;
    return (quot > ERR_MAX) ? ERR_MAX : quot[ERR_W-1:0];
  endfunction

  function automatic void predict_totals(input logic [SMP_W-1:0] orig,
                                         input logic [SMP_W-1:0] approx,
                                         input logic last);
    metric_result_t r;
    logic [ERR_W-1:0] e;
    e = pair_error(orig, approx);
    if (e > set_peak) set_peak = e;
    if (set_total > SUM_MAX - e) set_total = SUM_MAX;
    else set_total = set_total + e;
    if (set_count != CNT_MAX) set_count = set_count + 1'b1;
    r.rel = e;
    r.peak = set_peak;
    r.total = set_total;
    r.count = set_count;
    r.done = last;
    expected_results.push_back(r);
    if (last) begin
      set_peak = '0;
      set_total = '0;
      set_count = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    metric_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_rel_error), '0);
      end else begin
        want = expected_results.pop_front();
        if (out_rel_error !== want.rel)
          report_mismatch("rel_error", 64'(out_rel_error), 64'(want.rel));
        if (out_max_error !== want.peak)
          report_mismatch("max_error", 64'(out_max_error), 64'(want.peak));
        if (out_sum_error !== want.total)
          report_mismatch("sum_error", out_sum_error, want.total);
        if (out_item_count !== want.count)
          report_mismatch("item_count", 64'(out_item_count), 64'(want.count));
        if (out_set_done !== want.done)
          report_mismatch("set_done", 64'(out_set_done), 64'(want.done));
      end
    end
  end

  // receiver, with the long hold counted here
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  task automatic send_pair(input logic [SMP_W-1:0] orig, input logic [SMP_W-1:0] approx,
                           input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_original_sample <= orig;
    in_approx_sample <= approx;
    in_last_item <= last;
    do @(posedge clk); while (in_stall);
    predict_totals(orig, approx, last);
  endtask

  task automatic release_inputs();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (expected_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    release_inputs();
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_tolerance <= value;
    do @(posedge clk); while (!cfg_ready);
    tolerance_now = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_pair(input int last_odds);
    logic [SMP_W-1:0] o;
    logic [SMP_W-1:0] a;
    logic [SMP_W-1:0] d;
    o = $urandom;
    a = $urandom;
    case ($urandom_range(3))
      0: ;
      1: a = o + SMP_W'($urandom_range(2000)) - SMP_W'(1000);
      2: begin
        // magnitudes spread over every scale, near and around the tolerance
        o = $urandom & ((SMP_W'(1) << $urandom_range(31)) - 1'b1);
        if ($urandom_range(1)) o = -o;
        d = $urandom & ((SMP_W'(1) << $urandom_range(31)) - 1'b1);
        a = $urandom_range(1) ? o + d : o - d;
      end
      default: begin
        case ($urandom_range(4))
          0: o = '0;
          1: o = SMP_W'(1);
          2: o = '1;
          3: o = {1'b1, {(SMP_W-1){1'b0}}};
          default: o = {1'b0, {(SMP_W-1){1'b1}}};
        endcase
      end
    endcase
    send_pair(o, a, $urandom_range(last_odds - 1) == 0);
  endtask

  task automatic test_reset_tolerance();
    send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_pair(32'h0000_0000, 32'h7fff_ffff, 1'b0);
    send_pair(32'h0000_0000, 32'h8000_0000, 1'b0);
    send_pair(32'h0000_ffff, 32'hffff_0000, 1'b0);
    send_pair(32'h0001_0000, 32'h0000_0000, 1'b0);
    send_pair(32'hffff_0000, 32'h0001_0000, 1'b0);
    send_pair(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_pair(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_pair(32'h0003_0000, 32'h0003_0001, 1'b1);
  endtask

  task automatic test_tolerance_extremes();
    write_tolerance(TOL_W'(1));
    send_pair(32'h0000_0000, 32'h8000_0000, 1'b0);
    send_pair(32'h0000_0001, 32'h8000_0000, 1'b0);
    send_pair(32'hffff_ffff, 32'h7fff_ffff, 1'b0);
    send_pair(32'h0000_0001, 32'h0000_0001, 1'b1);
    write_tolerance(TOL_MAX);
    send_pair(32'h7fff_fffe, 32'h0000_0000, 1'b0);
    send_pair(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_pair(32'h8000_0000, 32'h0000_0000, 1'b0);
    send_pair(32'h1234_5678, 32'h9abc_def0, 1'b1);
  endtask

  task automatic test_zero_divisor();
    write_tolerance('0);
    send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_pair(32'h0000_0000, 32'hdead_beef, 1'b0);
    send_pair(32'h0000_0005, 32'h0000_0007, 1'b0);
    send_pair(32'h0000_0000, 32'h0000_0001, 1'b1);
  endtask

  task automatic test_random_traffic(input int n, input int src_pct, input int rcv_pct,
                                     input logic [TOL_W-1:0] tol);
    write_tolerance(tol);
    src_idle_pct = src_pct;
    rcv_stall_pct = rcv_pct;
    for (int i = 0; i < n - 1; i++) send_random_pair(12);
    send_random_pair(1);
  endtask

  task automatic test_output_backpressure();
    write_tolerance(TOL_RESET);
    src_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) send_random_pair(5);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_tolerance();
    test_tolerance_extremes();
    test_zero_divisor();
    test_random_traffic(130, 0, 0, TOL_RESET);
    test_random_traffic(130, 84, 0, TOL_W'($urandom_range(32'h7fff_ffff, 1)));
    test_random_traffic(130, 0, 84, TOL_MAX);
    test_random_traffic(130, 21, 21, TOL_W'(1));
    test_random_traffic(60, 21, 21, TOL_W'(1) << $urandom_range(30));
    test_output_backpressure();
    release_inputs();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### relative_error_metric.f
hdl/rerr_pkg.sv
hdl/rerr_ctrl.sv
hdl/rerr_dpath.sv
hdl/relative_error_metric.sv
sim/tb_relative_error_metric.sv
